### sv/ssa_pkg.sv
// Shared constants, types and codes for the swap slot allocator.
`default_nettype none
package ssa_pkg;

  localparam int NUM_SLOTS   = 256;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int GROUP_BITS  = 16;
  localparam int GROUP_POS_W = 4;
  localparam int GROUPS      = (NUM_SLOTS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GROUP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PAD_BITS    = GROUPS * GROUP_BITS;

  localparam int SLOT_W  = 8;
  localparam int PERM_W  = 12;
  localparam int BLOCK_W = 17;
  localparam int BASE_W  = 16;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

### sv/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/ssa_ffs.sv
// Find-first-set over one group of the free map: lowest free slot in the group.
`default_nettype none
module ssa_ffs
  import ssa_pkg::*;
(
  input  wire logic [GROUP_BITS-1:0]  free_bits,
  output logic                        hit,
  output logic      [GROUP_POS_W-1:0] pos
);

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit = 1'b1;
        pos = GROUP_POS_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

### sv/swap_slot_allocator.sv
// Top level: request sequencer, used map, permission store and result register.
`default_nettype none
// First-fit swap slot allocator. Each request beat carries the request kind in
// s_tuser and slot / permission in s_tdata; one result beat comes back per
// request. The used map lives in a RAM of 16-slot words. Allocate scans it one
// group per cycle through a shared find-first unit and stops at the group holding
// the lowest free slot, or after the last group. Free and lookup go through a map
// and permission RAM read, a check and a hand-off to the output register. The
// output register lets the next request enter while a result still waits for
// m_tready. After reset a clearing pass writes every used-map word to zero;
// s_tready stays low until it ends. The permission store needs no clearing: a
// slot's permission is only reported while its used bit is set, and an allocate
// writes it first.
module swap_slot_allocator
  import ssa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata,   // swap_base_block
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,     // [7:0] slot, [19:8] perm_in, zero pad
  input  wire logic [1:0]  s_tuser,     // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,     // [7:0] slot_out, [19:8] perm_out,
                                        // [36:20] first_block, zero pad
  output logic      [0:0]  m_tuser      // ok
);

  state_t state, state_next;

  logic [BASE_W-1:0]  base;

  func_t              req_func;
  logic [SLOT_W-1:0]  req_slot;
  logic [PERM_W-1:0]  req_perm;
  logic [GROUP_W-1:0] scan_group;

  logic               res_ok;
  logic [SLOT_W-1:0]  res_slot;
  logic [PERM_W-1:0]  res_perm;
  logic [BLOCK_W-1:0] res_block;

  logic                   ffs_hit;
  logic [GROUP_POS_W-1:0] ffs_pos;
  logic [GROUP_BITS-1:0]  group_free;
  logic [GROUP_BITS-1:0]  pad_mask;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W-1:0]       slot_idx;
  logic [GROUP_W-1:0]     slot_group;
  logic [GROUP_POS_W-1:0] slot_pos;
  logic                   slot_in_range;
  logic                   slot_used;
  logic                   last_group;

  logic                   accept;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [PERM_W-1:0]      ram_rdata;
  logic                   map_we;
  logic [GROUP_W-1:0]     map_waddr;
  logic [GROUP_BITS-1:0]  map_wdata;
  logic [GROUP_W-1:0]     map_raddr;
  logic [GROUP_BITS-1:0]  map_rdata;
  logic                   load_out;
  logic [BLOCK_W-1:0]     blk_off;
  logic [BLOCK_W-1:0]     blk_sum;

  // slots past the end read as used so the scan never picks them
  for (genvar g = 0; g < GROUP_BITS; g++) begin : g_pad
    if ((GROUPS - 1) * GROUP_BITS + g < NUM_SLOTS) begin : g_real
      assign pad_mask[g] = 1'b1;
    end else begin : g_fill
      assign pad_mask[g] = 1'b0;
    end
  end

  assign group_free = ~map_rdata & (last_group ? pad_mask : '1);
  assign found_idx  = IDX_W'({scan_group, ffs_pos});
  assign last_group = (scan_group == GROUP_W'(GROUPS - 1));

  assign slot_idx      = IDX_W'(req_slot);
  assign slot_group    = GROUP_W'(req_slot[SLOT_W-1:GROUP_POS_W]);
  assign slot_pos      = req_slot[GROUP_POS_W-1:0];
  assign slot_in_range = (32'(req_slot) < NUM_SLOTS);
  assign slot_used     = slot_in_range & map_rdata[slot_pos];

  assign accept = s_tvalid & s_tready;

  assign blk_off = (state == ST_SCAN) ? BLOCK_W'({found_idx, 3'b000})
                                      : BLOCK_W'({req_slot, 3'b000});
  assign blk_sum = BLOCK_W'(base) + blk_off;

  ssa_ffs u_ffs (
    .free_bits (group_free),
    .hit       (ffs_hit),
    .pos       (ffs_pos)
  );

  ssa_ram #(
    .WIDTH (PERM_W),
    .DEPTH (NUM_SLOTS)
  ) u_perm_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (found_idx),
    .wdata (req_perm),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssa_ram #(
    .WIDTH (GROUP_BITS),
    .DEPTH (GROUPS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (last_group) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(s_tuser))
            FUNC_ALLOC:              state_next = ST_SCAN;
            FUNC_FREE, FUNC_LOOKUP:  state_next = ST_CHECK;
            default:                 state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (ffs_hit || last_group) begin
          state_next = ST_FINISH;
        end
      end
      ST_CHECK:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    ram_raddr = IDX_W'(s_tdata[7:0]);
    map_we    = 1'b0;
    map_waddr = scan_group;
    map_wdata = '0;
    map_raddr = scan_group;
    case (state)
      ST_CLEAR:  map_we = 1'b1;
      ST_IDLE: begin
        s_tready  = 1'b1;
        map_raddr = (func_t'(s_tuser) == FUNC_ALLOC) ? '0
                                                     : GROUP_W'(s_tdata[7:GROUP_POS_W]);
      end
      ST_SCAN: begin
        ram_we    = ffs_hit;
        map_we    = ffs_hit;
        map_wdata = map_rdata | (GROUP_BITS'(1) << ffs_pos);
        // prefetch the next group so the scan keeps one group per cycle
        map_raddr = scan_group + GROUP_W'(1);
      end
      ST_CHECK: begin
        ram_raddr = slot_idx;
        map_we    = (req_func == FUNC_FREE) && slot_in_range;
        map_waddr = slot_group;
        map_wdata = map_rdata & ~(GROUP_BITS'(1) << slot_pos);
      end
      ST_FINISH: load_out = !m_tvalid || m_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      base       <= '0;
      m_tvalid   <= 1'b0;
      scan_group <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        base <= cfg_wdata;
      end
      if (accept) begin
        scan_group <= '0;
      end else if (state == ST_CLEAR || (state == ST_SCAN && !ffs_hit && !last_group)) begin
        scan_group <= scan_group + GROUP_W'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func  <= func_t'(s_tuser);
      req_slot  <= s_tdata[7:0];
      req_perm  <= s_tdata[19:8];
      res_ok    <= 1'b0;
      res_slot  <= '0;
      res_perm  <= '0;
      res_block <= '0;
    end
    if (state == ST_SCAN && ffs_hit) begin
      res_ok    <= 1'b1;
      res_slot  <= SLOT_W'(found_idx);
      res_perm  <= req_perm;
      res_block <= blk_sum;
    end
    if (state == ST_CHECK) begin
      res_ok    <= slot_used;
      res_slot  <= req_slot;
      res_perm  <= (req_func == FUNC_LOOKUP && slot_used) ? ram_rdata : '0;
      res_block <= blk_sum;
    end
    if (load_out) begin
      m_tdata <= {3'b000, res_block, res_perm, res_slot};
      m_tuser <= res_ok;
    end
  end

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the swap slot allocator: directed and random requests.
`default_nettype none
module testbench;
  import ssa_pkg::*;

  localparam int LONG_STALL = 400;

  typedef struct packed {
    logic        ok;
    logic [7:0]  slot_out;
    logic [11:0] perm_out;
    logic [16:0] first_block;
  } swap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  func_t       s_tuser = FUNC_ALLOC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  // predictor state
  logic        slot_free [NUM_SLOTS];
  logic [11:0] slot_perm [NUM_SLOTS];
  logic [15:0] swap_base;
  int          slots_in_use;

  swap_result_t expected_results [$];
  int mismatch_count = 0;
  int sender_burst = 0;
  int stall_requests = 0;
  int stalls_served = 0;
  int hold_left = 0;
  int ready_run = 0;

  swap_slot_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [16:0] block_of(int idx);
    return 17'(swap_base) + (17'(idx) << 3);
  endfunction

  function automatic swap_result_t predict_request(func_t f, logic [7:0] sl, logic [11:0] pm);
    swap_result_t r;
    int idx;
    r = '0;
    idx = -1;
    case (f)
      FUNC_ALLOC: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_free[i] && idx < 0) idx = i;
        if (idx >= 0) begin
          slot_free[idx] = 1'b0;
          slot_perm[idx] = pm;
          slots_in_use++;
          r.ok = 1'b1;
          r.slot_out = 8'(idx);
          r.perm_out = pm;
          r.first_block = block_of(idx);
        end
      end
      FUNC_FREE, FUNC_LOOKUP: begin
        r.slot_out = sl;
        r.first_block = block_of(int'(sl));
        if (int'(sl) < NUM_SLOTS) begin
          r.ok = !slot_free[sl];
          if (f == FUNC_FREE) begin
            if (!slot_free[sl]) slots_in_use--;
            slot_free[sl] = 1'b1;
            slot_perm[sl] = '0;
          end else if (r.ok) begin
            r.perm_out = slot_perm[sl];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int sender_gap();
    int r;
    if (sender_burst > 0) begin
      sender_burst--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) sender_burst = $urandom_range(60, 10);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [11:0] random_perm();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  // mostly a slot that is in use, else any slot
  function automatic logic [7:0] pick_slot(int used_pct);
    int start;
    int idx;
    if (slots_in_use > 0 && $urandom_range(99) < used_pct) begin
      start = $urandom_range(NUM_SLOTS - 1);
      for (int k = 0; k < NUM_SLOTS; k++) begin
        idx = (start + k) % NUM_SLOTS;
        if (!slot_free[idx]) return 8'(idx);
      end
    end
    return 8'($urandom);
  endfunction

  task automatic send_request(input func_t f, input logic [7:0] sl, input logic [11:0] pm);
    int gap;
    gap = sender_gap();
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'b0, pm, sl};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_request(f, sl, pm));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_swap_base(input logic [15:0] value);
    wait_drained();
    repeat (25) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    swap_base = value;
  endtask

  task automatic test_directed_requests();
    send_request(FUNC_LOOKUP, 8'd0, 12'hFFF);    // lookup of a free slot
    send_request(FUNC_FREE, 8'd255, 12'hFFF);    // free of a free slot
    send_request(FUNC_NONE, 8'd255, 12'hFFF);    // unused code
    send_request(FUNC_NONE, 8'd0, 12'h000);
    send_request(FUNC_ALLOC, 8'd255, 12'hFFF);
    send_request(FUNC_ALLOC, 8'd0, 12'h000);
    send_request(FUNC_ALLOC, 8'd77, 12'hA5A);
    send_request(FUNC_LOOKUP, 8'd0, 12'h000);
    send_request(FUNC_LOOKUP, 8'd1, 12'h000);
    send_request(FUNC_LOOKUP, 8'd2, 12'h000);
    send_request(FUNC_LOOKUP, 8'd255, 12'h000);
    send_request(FUNC_FREE, 8'd1, 12'h000);
    send_request(FUNC_LOOKUP, 8'd1, 12'h000);
    send_request(FUNC_ALLOC, 8'd0, 12'h5A5);     // reuses the hole at 1
    send_request(FUNC_FREE, 8'd0, 12'h000);
    send_request(FUNC_FREE, 8'd0, 12'h000);      // double free
    send_request(FUNC_LOOKUP, 8'd0, 12'hFFF);
    send_request(FUNC_ALLOC, 8'd0, 12'h800);
  endtask

  task automatic test_base_extremes();
    set_swap_base(16'hFFFF);
    send_request(FUNC_ALLOC, 8'd0, 12'h123);
    send_request(FUNC_LOOKUP, 8'd255, 12'h000);
    send_request(FUNC_FREE, 8'd255, 12'h000);
    send_request(FUNC_LOOKUP, 8'd0, 12'h000);
    set_swap_base(16'h0000);
    send_request(FUNC_LOOKUP, 8'd3, 12'h000);
  endtask

  task automatic test_table_full();
    set_swap_base(16'h1234);
    while (slots_in_use < NUM_SLOTS)
      send_request(FUNC_ALLOC, 8'($urandom), random_perm());
    repeat (3) send_request(FUNC_ALLOC, 8'hFF, 12'hFFF);  // no free slot left
    send_request(FUNC_LOOKUP, 8'd255, 12'h000);
    send_request(FUNC_FREE, 8'd128, 12'h000);
    send_request(FUNC_FREE, 8'd7, 12'h000);
    send_request(FUNC_ALLOC, 8'd0, 12'hABC);
    send_request(FUNC_ALLOC, 8'd0, 12'hDEF);
    send_request(FUNC_ALLOC, 8'd0, 12'h111);
    send_request(FUNC_LOOKUP, 8'd7, 12'h000);
    send_request(FUNC_LOOKUP, 8'd128, 12'h000);
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_output_stall();
    stall_requests++;
    for (int k = 0; k < 40; k++)
      if (k % 3 == 0) send_request(FUNC_ALLOC, 8'($urandom), random_perm());
      else send_request(func_t'(k % 3 == 1 ? FUNC_FREE : FUNC_LOOKUP), pick_slot(70),
                        12'($urandom));
    wait_drained();
  endtask

  task automatic test_random_mix(input int items, input int alloc_pct, input logic [15:0] base);
    int r;
    set_swap_base(base);
    repeat (items) begin
      if ($urandom_range(149) == 0) wait_drained();
      r = $urandom_range(99);
      if (r < alloc_pct)
        send_request(FUNC_ALLOC, 8'($urandom), random_perm());
      else if (r < alloc_pct + (100 - alloc_pct) / 2)
        send_request(FUNC_FREE, pick_slot(75), 12'($urandom));
      else if (r < 97)
        send_request(FUNC_LOOKUP, pick_slot(60), 12'($urandom));
      else
        send_request(FUNC_NONE, 8'($urandom), 12'($urandom));
    end
  endtask

  // result sink pacing: random ready/idle runs plus requested long hold-offs
  always @(posedge clk) begin : sink_pace
    int r;
    r = $urandom_range(99);
    if (stalls_served != stall_requests) begin
      stalls_served <= stall_requests;
      hold_left <= LONG_STALL;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      ready_run <= (r < 92) ? $urandom_range(2) : $urandom_range(40, 10);
    end else begin
      m_tready <= 1'b1;
      ready_run <= (r < 95) ? $urandom_range(6) : $urandom_range(120, 40);
    end
  end

  always @(posedge clk) begin : result_check
    swap_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: slot_out %0d", m_tdata[7:0]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tdata[7:0] !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[19:8] !== want.perm_out) begin
          $error("perm_out: expected 0x%03h, got 0x%03h", want.perm_out, m_tdata[19:8]);
          mismatch_count++;
        end
        if (m_tdata[36:20] !== want.first_block) begin
          $error("first_block: expected %0d, got %0d", want.first_block, m_tdata[36:20]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_free[i] = 1'b1;
      slot_perm[i] = '0;
    end
    swap_base = '0;
    slots_in_use = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_requests();
    test_base_extremes();
    test_table_full();
    test_output_stall();
    test_random_mix(125, 50, 16'($urandom));
    test_random_mix(125, 70, 16'hFFFF);
    test_random_mix(125, 25, 16'h0000);
    test_random_mix(125, 45, 16'($urandom));
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
sv/ssa_pkg.sv
sv/ssa_ram.sv
sv/ssa_ffs.sv
sv/swap_slot_allocator.sv
test/testbench.sv
